>>> rtl/core/bmaff_pkg.sv
// Shared types and constants of the bit map allocator with find-first searches.
package bmaff_pkg;

  localparam int WORD_BITS    = 64;
  localparam int BIT_W        = 6;
  localparam int IDX_W        = 12;
  localparam int CNT_W        = 13;
  localparam int OP_W         = 3;
  localparam int MAP_BITS_MAX = 4096;
  localparam int CNT_RESET    = 4096;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 16;

  localparam logic [OP_W-1:0] OP_SET      = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd1;
  localparam logic [OP_W-1:0] OP_READ     = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND_CLR = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND_SET = 3'd4;

  typedef struct packed {
    logic load;
    logic rd_word;
    logic update;
    logic scan;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bit_op;
    logic search;
    logic scan_done;
  } ctrl_sts_t;

endpackage

>>> rtl/core/bitmap_allocator_find_first_core.sv
// Top level of the bit map allocator with find-first-clear and find-first-set searches.
//
// Input channel in_*: one request per item, operation set, clear, read bit, find first
// clear or find first set, with a bit index. Result channel out_*: one result per item,
// in request order. cfg_we/cfg_wdata write the bit count; write it only while idle.
// Set, clear and read pass through decode, one memory read and a read-modify-write
// before the result enters the output register. A search reads one 64-bit map word per
// cycle through the map memory's single read port, up to the first hit or the end of
// the bit count (at most 64 words). A new item is taken only after the previous result
// enters the output register. Unknown operations give an all-zero result.
// Reset clears the map through per-word valid bits at once and sets the bit count
// to 4096; no sweep is needed. A result waits in the output register while out_tready
// is low; the next item can be accepted and worked on meanwhile, and its result is
// held inside until the output register frees up.
module bitmap_allocator_find_first_core
  import bmaff_pkg::*;
#(
  parameter int MAX_BITS = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CNT_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [2:0] operation, [14:3] index, [15] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] in_range, [1] bit_value, [2] found, [14:3] found_index, [15] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  ctrl_cmd_t        cmd;
  ctrl_sts_t        sts;
  logic             res_in_range, res_bit_value, res_found;
  logic [IDX_W-1:0] res_found_index;

  bmaff_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bmaff_dp #(
    .MAX_BITS (MAX_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_op           (in_tdata[OP_W-1:0]),
    .in_idx          (in_tdata[OP_W +: IDX_W]),
    .cmd             (cmd),
    .sts             (sts),
    .out_in_range    (res_in_range),
    .out_bit_value   (res_bit_value),
    .out_found       (res_found),
    .out_found_index (res_found_index)
  );

  assign out_tdata = {1'b0, res_found_index, res_found, res_bit_value, res_in_range};

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("result loaded while the output register was still occupied");

  // A word update always works on the word read in the cycle before.
  a_update_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> $past(cmd.rd_word))
    else $error("word update without a preceding read");

  // Once an item is taken, the block is busy until its result enters the output register.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after an accepted item");

  // A scan finishes only while a scan is running.
  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (sts.scan_done && !cmd.scan) |-> !cmd.emit)
    else $error("scan completion seen outside a scan");

endmodule

>>> rtl/core/bmaff_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmaff_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/bmaff_ctrl.sv
// Controller state machine: sequences accept, word access, scan and result hand-off.
module bmaff_ctrl
  import bmaff_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  ctrl_sts_t  sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_ACCESS = 5'b00100,
    S_SCAN   = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r & ~out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.bit_op) begin
          cmd.rd_word = 1'b1;
          state_nxt   = S_ACCESS;
        end else if (sts.search) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_ACCESS: begin
        cmd.update = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        // The result waits here until the output register is free.
        if (!out_valid_r || out_tready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

>>> rtl/core/bmaff_dp.sv
// Datapath: bit count register, map memory with valid bits, word update and scan logic.
module bmaff_dp
  import bmaff_pkg::*;
#(
  parameter int MAX_BITS = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic [OP_W-1:0]  in_op,
  input  logic [IDX_W-1:0] in_idx,
  input  ctrl_cmd_t        cmd,
  output ctrl_sts_t        sts,
  output logic             out_in_range,
  output logic             out_bit_value,
  output logic             out_found,
  output logic [IDX_W-1:0] out_found_index
);

  localparam int EFF_BITS = (MAX_BITS < MAP_BITS_MAX) ? MAX_BITS : MAP_BITS_MAX;
  localparam int DEPTH    = (EFF_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] EFF_CNT  = CNT_W'(EFF_BITS);
  localparam logic [WW-1:0]    LAST_W   = WW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] WORD_CNT = CNT_W'(WORD_BITS);

  logic [CNT_W-1:0]     cnt_r;
  logic [OP_W-1:0]      op_r;
  logic [IDX_W-1:0]     idx_r;
  logic [WW-1:0]        scan_addr_r;
  logic [WW-1:0]        chk_w_r;
  logic                 pend_r;
  logic                 vld_rd_r;
  logic [DEPTH-1:0]     valid_r;
  logic                 res_inr_r, res_bv_r, res_found_r;
  logic [IDX_W-1:0]     res_fidx_r;
  logic                 out_inr_r, out_bv_r, out_found_r;
  logic [IDX_W-1:0]     out_fidx_r;

  logic [CNT_W-1:0]     live;
  logic                 inr;
  logic [WW-1:0]        idx_w;
  logic [WORD_BITS-1:0] rdata, word_q, wdata, bit_mask;
  logic                 re, re_word, re_scan, we;
  logic [WW-1:0]        raddr;
  logic [CNT_W-1:0]     lo, n;
  logic [WORD_BITS-1:0] wmask, cand, onehot;
  logic                 want, hit, last, scan_done;
  logic [BIT_W-1:0]     pos;
  logic                 is_set, is_clr, is_read;

  assign live  = (cnt_r > EFF_CNT) ? EFF_CNT : cnt_r;
  assign inr   = {1'b0, idx_r} < live;
  assign idx_w = idx_r[BIT_W +: WW];

  always_comb begin
    sts.bit_op    = 1'b0;
    sts.search    = 1'b0;
    sts.scan_done = scan_done;
    unique case (op_r) inside
      OP_SET, OP_CLEAR, OP_READ: sts.bit_op = 1'b1;
      OP_FIND_CLR, OP_FIND_SET:  sts.search = 1'b1;
      default: ;
    endcase
  end

  assign is_set  = (op_r == OP_SET);
  assign is_clr  = (op_r == OP_CLEAR);
  assign is_read = (op_r == OP_READ);
  assign want    = (op_r == OP_FIND_SET);

  // Words never written read as zero through their valid bit.
  assign word_q = vld_rd_r ? rdata : '0;

  // Scan check of the word returned by the previous read.
  assign lo = CNT_W'(chk_w_r) << BIT_W;
  assign n  = live - lo;
  always_comb begin
    if (live <= lo) begin
      wmask = '0;
    end else if (n >= WORD_CNT) begin
      wmask = '1;
    end else begin
      wmask = ~({WORD_BITS{1'b1}} << n[BIT_W-1:0]);
    end
  end

  assign cand      = (want ? word_q : ~word_q) & wmask;
  assign hit       = |cand;
  assign onehot    = cand & (~cand + WORD_BITS'(1));
  assign last      = (live <= lo + WORD_CNT) || (chk_w_r == LAST_W);
  assign scan_done = pend_r && (hit || last);

  always_comb begin
    pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot[i]) begin
        pos = pos | BIT_W'(i);
      end
    end
  end

  // Word access and scan reads share the single read port.
  assign re_word = cmd.rd_word & inr;
  assign re_scan = cmd.scan & ~scan_done;
  assign re      = re_word | re_scan;
  assign raddr   = cmd.rd_word ? idx_w : scan_addr_r;

  assign bit_mask = WORD_BITS'(1) << idx_r[BIT_W-1:0];
  assign wdata    = is_set ? (word_q | bit_mask) : (word_q & ~bit_mask);
  assign we       = cmd.update & inr & (is_set | is_clr);

  bmaff_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (idx_w),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= CNT_W'(CNT_RESET);
      valid_r <= '0;
    end else begin
      if (cfg_we) begin
        cnt_r <= cfg_wdata;
      end
      if (we) begin
        valid_r[idx_w] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (cmd.load) begin
      pend_r <= 1'b0;
    end else if (cmd.scan) begin
      pend_r <= re_scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= in_op;
      idx_r       <= in_idx;
      scan_addr_r <= '0;
      res_inr_r   <= 1'b0;
      res_bv_r    <= 1'b0;
      res_found_r <= 1'b0;
      res_fidx_r  <= '0;
    end
    if (re) begin
      vld_rd_r <= valid_r[raddr];
      chk_w_r  <= raddr;
    end
    if (re_scan) begin
      scan_addr_r <= scan_addr_r + WW'(1);
    end
    if (cmd.update) begin
      res_inr_r <= inr;
      res_bv_r  <= is_read & inr & word_q[idx_r[BIT_W-1:0]];
    end
    if (cmd.scan && scan_done && hit) begin
      res_found_r <= 1'b1;
      res_fidx_r  <= (IDX_W'(chk_w_r) << BIT_W) | IDX_W'(pos);
    end
    if (cmd.emit) begin
      out_inr_r   <= res_inr_r;
      out_bv_r    <= res_bv_r;
      out_found_r <= res_found_r;
      out_fidx_r  <= res_fidx_r;
    end
  end

  assign out_in_range    = out_inr_r;
  assign out_bit_value   = out_bv_r;
  assign out_found       = out_found_r;
  assign out_found_index = out_fidx_r;

endmodule

>>> bench/bitmap_allocator_find_first_core_test.sv
// Self-checking testbench for the bit map allocator with find-first-clear and find-first-set.
`timescale 1ns / 100ps

module bitmap_allocator_find_first_core_test;
  import bmaff_pkg::*;

  localparam int NUM_WORDS = MAP_BITS_MAX / WORD_BITS;
  localparam int IDLE_LIMIT = 4000;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASE_ITEMS = 80;
  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam int NUM_SPARE_OPS = 3;

  typedef enum int {READY_ALWAYS, READY_RANDOM, READY_STRETCH} ready_mode_t;

  // Packed in the order of out_tdata, lowest bit last.
  typedef struct packed {
    logic [IDX_W-1:0] found_index;
    logic             found;
    logic             bit_value;
    logic             in_range;
  } answer_t;

  class bitmap_scoreboard;
    logic [WORD_BITS-1:0] words [NUM_WORDS];
    logic [CNT_W-1:0]     count;
    answer_t              awaited_answers[$];
    int                   failures;
    int                   reports;

    function new();
      foreach (words[i]) words[i] = '0;
      count = CNT_W'(CNT_RESET);
      failures = 0;
      reports = 0;
    endfunction

    function void set_count(logic [CNT_W-1:0] value);
      count = value;
    endfunction

    function int pending();
      return awaited_answers.size();
    endfunction

    function int live_bits();
      return (count > MAP_BITS_MAX) ? MAP_BITS_MAX : int'(count);
    endfunction

    // Lowest index below the live count whose bit equals want.
    function void find_lowest(bit want, output bit hit, output logic [IDX_W-1:0] where);
      int live;
      int lo;
      int n;
      logic [WORD_BITS-1:0] mask;
      logic [WORD_BITS-1:0] cand;
      hit = 1'b0;
      where = '0;
      live = live_bits();
      for (int w = 0; w < NUM_WORDS; w++) begin
        lo = w * WORD_BITS;
        if (live <= lo) break;
        n = live - lo;
        mask = (n >= WORD_BITS) ? '1 : ((64'd1 << n) - 64'd1);
        cand = (want ? words[w] : ~words[w]) & mask;
        if (cand != '0) begin
          for (int b = 0; b < WORD_BITS; b++) begin
            if (cand[b]) begin
              hit = 1'b1;
              where = IDX_W'(lo + b);
              return;
            end
          end
        end
      end
    endfunction

    function void note_request(logic [IN_TDATA_W-1:0] data);
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] where;
      answer_t          ans;
      bit               inr;
      bit               hit;
      op = data[OP_W-1:0];
      idx = data[OP_W +: IDX_W];
      ans = '0;
      inr = int'(idx) < live_bits();
      case (op)
        OP_SET: begin
          ans.in_range = inr;
          if (inr) words[idx[IDX_W-1:BIT_W]][idx[BIT_W-1:0]] = 1'b1;
        end
        OP_CLEAR: begin
          ans.in_range = inr;
          if (inr) words[idx[IDX_W-1:BIT_W]][idx[BIT_W-1:0]] = 1'b0;
        end
        OP_READ: begin
          ans.in_range = inr;
          if (inr) ans.bit_value = words[idx[IDX_W-1:BIT_W]][idx[BIT_W-1:0]];
        end
        OP_FIND_CLR, OP_FIND_SET: begin
          find_lowest(op == OP_FIND_SET, hit, where);
          ans.found = hit;
          ans.found_index = where;
        end
        default: ;
      endcase
      awaited_answers.push_back(ans);
    endfunction

    function void check_answer(logic [OUT_TDATA_W-1:0] data);
      answer_t got;
      answer_t want;
      got = data[$bits(answer_t)-1:0];
      if (awaited_answers.size() == 0) begin
        failures++;
        if (reports < REPORT_LIMIT)
          $display("Result %h arrived with no request waiting", data);
        reports++;
        return;
      end
      want = awaited_answers.pop_front();
      if (got.in_range !== want.in_range || got.bit_value !== want.bit_value ||
          got.found !== want.found || got.found_index !== want.found_index) begin
        failures++;
        if (reports < REPORT_LIMIT)
          $display({"Mismatch: expected in_range %0d bit_value %0d found %0d index %0d,",
                    " got in_range %0d bit_value %0d found %0d index %0d"},
                   want.in_range, want.bit_value, want.found, want.found_index,
                   got.in_range, got.bit_value, got.found, got.found_index);
        reports++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  bitmap_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 1;
  int fill_next = 0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int mode_left = 0;
  int hold_left = 0;

  bitmap_allocator_find_first_core #(
    .MAX_BITS(MAP_BITS_MAX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tdata);
      if (out_tvalid && out_tready) sb.check_answer(out_tdata);
      idle_cycles <= ((in_tvalid && in_tready) || (out_tvalid && out_tready)) ?
                     0 : idle_cycles + 1;
    end
  end

  // Receiver: modes of always ready, random ready, and long ready/stall stretches.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      mode_left <= $urandom_range(50, 300);
      ready_mode <= ready_mode_t'($urandom_range(0, 2));
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS: out_tready <= 1'b1;
      READY_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (hold_left == 0) begin
          out_tready <= ~out_tready;
          hold_left <= out_tready ? $urandom_range(1, 24) : $urandom_range(1, 8);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  initial begin
    do @(posedge clk); while (idle_cycles < IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W-OP_W-IDX_W){1'b0}}, idx, op};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) :
                   $urandom_range(1, 12);
    end
  endtask

  task automatic wait_drained();
    // One edge first, so an item accepted at the edge just passed is already noted.
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_bit_count(logic [CNT_W-1:0] value);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_count(value);
  endtask

  // Indices lean toward the live range and its upper edge.
  function automatic logic [IDX_W-1:0] pick_index(int live);
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = int'(IDX_MAX);
      2, 3: v = live - 2 + int'($urandom_range(0, 3));
      4: v = $urandom_range(0, int'(IDX_MAX));
      default: v = (live > 0) ? $urandom_range(0, live - 1) : $urandom_range(0, int'(IDX_MAX));
    endcase
    if (v < 0) v = 0;
    if (v > int'(IDX_MAX)) v = int'(IDX_MAX);
    return IDX_W'(v);
  endfunction

  function automatic logic [IDX_W-1:0] any_index();
    return IDX_W'($urandom_range(0, int'(IDX_MAX)));
  endfunction

  task automatic run_phase(int items);
    int done;
    int live;
    int k;
    logic [IDX_W-1:0] start;
    done = 0;
    live = sb.live_bits();
    while (done < items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // Allocate a run of bits from the front, then look for the next free one.
          k = (live > 256) ? $urandom_range(1, 120) : $urandom_range(1, 40);
          for (int j = 0; j < k; j++) begin
            if (fill_next >= live) fill_next = 0;
            send_request(OP_SET, (live > 0) ? IDX_W'(fill_next) : pick_index(live));
            fill_next++;
          end
          send_request(OP_FIND_CLR, any_index());
          done += k + 1;
        end
        4: begin
          start = pick_index(live);
          k = $urandom_range(1, 20);
          for (int j = 0; j < k; j++) send_request(OP_CLEAR, start + IDX_W'(j));
          send_request(OP_FIND_SET, any_index());
          send_request(OP_FIND_CLR, any_index());
          done += k + 2;
        end
        5: begin
          start = pick_index(live);
          send_request(OP_SET, start);
          send_request(OP_READ, start);
          send_request(OP_CLEAR, start);
          send_request(OP_READ, start);
          send_request(OP_FIND_SET, any_index());
          done += 5;
        end
        6, 7, 8: begin
          if ($urandom_range(0, 7) == 0)
            send_request(OP_W'(OP_SPARE_FIRST + $urandom_range(0, NUM_SPARE_OPS - 1)),
                         any_index());
          else
            send_request(OP_W'($urandom_range(0, int'(OP_FIND_SET))), pick_index(live));
          done += 1;
        end
        default: begin
          send_request(OP_FIND_CLR, any_index());
          send_request(OP_FIND_SET, any_index());
          done += 2;
        end
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty map at the reset count: a clear bit at once, then a full scan for a set one.
    send_request(OP_FIND_CLR, '0);
    send_request(OP_FIND_SET, '0);
    send_request(OP_SET, '0);
    send_request(OP_SET, IDX_MAX);
    send_request(OP_READ, IDX_MAX);
    send_request(OP_READ, 12'd1);
    send_request(OP_FIND_SET, '0);
    send_request(OP_CLEAR, '0);
    send_request(OP_FIND_SET, '0);
    send_request(OP_FIND_CLR, IDX_MAX);
    for (int k = 0; k < NUM_SPARE_OPS; k++)
      send_request(OP_W'(OP_SPARE_FIRST + k), IDX_MAX);

    // With no bits in use everything is out of range and nothing is found.
    set_bit_count('0);
    send_request(OP_SET, 12'd5);
    send_request(OP_READ, 12'd5);
    send_request(OP_FIND_CLR, '0);
    send_request(OP_FIND_SET, '0);

    // A count past the map size saturates; the top bit stays visible.
    set_bit_count(CNT_MAX);
    send_request(OP_READ, IDX_MAX);
    send_request(OP_FIND_SET, '0);

    // Lowered count hides the top bit but keeps it.
    set_bit_count(13'd64);
    send_request(OP_SET, 12'd63);
    send_request(OP_SET, 12'd64);
    send_request(OP_READ, 12'd64);
    send_request(OP_FIND_SET, '0);
    send_request(OP_READ, IDX_MAX);

    set_bit_count(13'd1);
    run_phase(PHASE_ITEMS);
    set_bit_count(13'd63);
    run_phase(PHASE_ITEMS);
    set_bit_count(13'd64);
    run_phase(PHASE_ITEMS);
    set_bit_count(13'd65);
    run_phase(PHASE_ITEMS);
    set_bit_count(13'd127);
    run_phase(PHASE_ITEMS);
    set_bit_count(CNT_W'(CNT_RESET));
    run_phase(PHASE_ITEMS);
    set_bit_count(CNT_MAX);
    run_phase(PHASE_ITEMS);
    set_bit_count('0);
    run_phase(PHASE_ITEMS / 2);
    set_bit_count(13'd200);
    run_phase(PHASE_ITEMS);
    set_bit_count(CNT_W'($urandom_range(0, int'(CNT_MAX))));
    run_phase(PHASE_ITEMS);
    set_bit_count(13'd4095);
    run_phase(PHASE_ITEMS);
    set_bit_count(13'd130);
    run_phase(PHASE_ITEMS);

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/bmaff_pkg.sv
rtl/core/bmaff_ram.sv
rtl/core/bmaff_ctrl.sv
rtl/core/bmaff_dp.sv
rtl/core/bitmap_allocator_find_first_core.sv
bench/bitmap_allocator_find_first_core_test.sv
